[design/hid_keyboard_report_diff_unit_macros.svh]
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff_unit_macros
// Assertion macros used by the top-level design file.
// ----------------------------------------------------------------------------
// Each macro takes a label, a clock, an active-low reset and the expressions.
`ifndef HID_KEYBOARD_REPORT_DIFF_UNIT_MACROS_SVH
`define HID_KEYBOARD_REPORT_DIFF_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hkrd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HKRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hkrd assertion failed");

`endif

[design/hkrd_pkg.sv]
// ----------------------------------------------------------------------------
// hkrd_pkg
// Types and constants shared by the keyboard report difference unit.
// ----------------------------------------------------------------------------
package hkrd_pkg;

	localparam int KeySlots     = 6;
	localparam int ModBits      = 8;
	localparam int MinReportLen = 8;
	localparam int EventSlots   = ModBits + 2 * KeySlots;

	// Values of the event kind field.
	localparam logic KindModifier = 1'b0;
	localparam logic KindKey      = 1'b1;

	typedef struct packed {
		logic [7:0] report_length;
		logic [7:0] modifier_byte;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic       event_kind;
		logic [7:0] event_code;
		logic       is_press;
		logic [7:0] modifier_snapshot;
		logic       last_event;
	} event_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic calc;
		logic emit;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic report_ok;
		logic mask_empty;
		logic last_pick;
		logic slot_free;
	} ctrl_sts_t;

endpackage

[design/hkrd_stream_if.sv]
// ----------------------------------------------------------------------------
// hkrd_stream_if
// Valid/ready channel that carries one item of a given payload type.
// ----------------------------------------------------------------------------
interface hkrd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/hkrd_ctrl.sv]
// ----------------------------------------------------------------------------
// hkrd_ctrl
// Controller: accepts a report, starts the compare, steps the event emission
// one item per cycle while the output is free, then commits the report.
// ----------------------------------------------------------------------------
module hkrd_ctrl
	import hkrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      report_valid,
	output logic      report_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Commands follow from the state and the datapath status.
	always_comb begin
		cmd          = '0;
		report_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				report_ready = 1'b1;
				cmd.load     = report_valid && sts.report_ok;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_EMIT: begin
				if (sts.mask_empty) begin
					cmd.commit = 1'b1;
				end else if (sts.slot_free) begin
					cmd.emit   = 1'b1;
					cmd.commit = sts.last_pick;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/hkrd_datapath.sv]
// ----------------------------------------------------------------------------
// hkrd_datapath
// Holds the current and previous report, builds the mask of pending events
// and drives the registered event output.
// ----------------------------------------------------------------------------
module hkrd_datapath
	import hkrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  report_t               report,
	input  ctrl_cmd_t             cmd,
	output ctrl_sts_t             sts,
	hkrd_stream_if.source         event_ch
);

	logic                         enable_q;
	logic [ModBits-1:0]           cur_mods_q;
	logic [KeySlots-1:0][7:0]     cur_keys_q;
	logic [ModBits-1:0]           prior_mods_q;
	logic [KeySlots-1:0][7:0]     prior_keys_q;
	logic [EventSlots-1:0]        mask_q;
	logic                         out_valid_q;
	event_t                       out_q;

	logic [KeySlots-1:0][7:0]     in_keys;
	logic [EventSlots-1:0]        mask_d;
	logic [EventSlots-1:0]        pick;
	event_t                       ev;

	assign in_keys = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
		report.key_slot_2, report.key_slot_1, report.key_slot_0};

	// Pending events: modifier changes, then presses, then releases.
	always_comb begin
		logic hit_prior;
		logic hit_cur;
		mask_d[ModBits-1:0] = cur_mods_q ^ prior_mods_q;
		for (int i = 0; i < KeySlots; i++) begin
			hit_prior = 1'b0;
			hit_cur   = 1'b0;
			for (int j = 0; j < KeySlots; j++) begin
				if (prior_keys_q[j] == cur_keys_q[i]) hit_prior = 1'b1;
				if (cur_keys_q[j] == prior_keys_q[i]) hit_cur = 1'b1;
			end
			mask_d[ModBits+i]          = (cur_keys_q[i] != 8'd0) && !hit_prior;
			mask_d[ModBits+KeySlots+i] = (prior_keys_q[i] != 8'd0) && !hit_cur;
		end
	end

	// Lowest pending event and its fields.
	assign pick = mask_q & (~mask_q + EventSlots'(1));

	always_comb begin
		ev            = '0;
		ev.last_event = ((mask_q & ~pick) == '0);
		for (int i = 0; i < ModBits; i++) begin
			if (pick[i]) begin
				ev.event_kind        = KindModifier;
				ev.event_code        = 8'(i);
				ev.is_press          = cur_mods_q[i];
				ev.modifier_snapshot = cur_mods_q;
			end
		end
		for (int i = 0; i < KeySlots; i++) begin
			if (pick[ModBits+i]) begin
				ev.event_kind        = KindKey;
				ev.event_code        = cur_keys_q[i];
				ev.is_press          = 1'b1;
				ev.modifier_snapshot = cur_mods_q;
			end
			if (pick[ModBits+KeySlots+i]) begin
				ev.event_kind        = KindKey;
				ev.event_code        = prior_keys_q[i];
				ev.is_press          = 1'b0;
				ev.modifier_snapshot = prior_mods_q;
			end
		end
	end

	// Status toward the controller.
	assign sts.report_ok  = enable_q && (report.report_length >= 8'(MinReportLen));
	assign sts.mask_empty = (mask_q == '0);
	assign sts.last_pick  = ev.last_event;
	assign sts.slot_free  = !out_valid_q || event_ch.ready;

	// Control registers: enable, pending mask, prior report, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			mask_q       <= '0;
			prior_mods_q <= '0;
			prior_keys_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) enable_q <= cfg_wdata;
			if (cmd.calc) begin
				mask_q <= mask_d;
			end else if (cmd.emit) begin
				mask_q <= mask_q & ~pick;
			end
			if (cmd.commit) begin
				prior_mods_q <= cur_mods_q;
				prior_keys_q <= cur_keys_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (event_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: captured report and output item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_mods_q <= report.modifier_byte;
			cur_keys_q <= in_keys;
		end
		if (cmd.emit) out_q <= ev;
	end

	assign event_ch.valid = out_valid_q;
	assign event_ch.data  = out_q;

endmodule

[design/hid_keyboard_report_diff_unit.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff_unit
// Compares each boot keyboard report with the previous one and emits one
// item per modifier change, key press and key release.
// ----------------------------------------------------------------------------
//  channel    dir  payload   handshake
//  report_ch  in   report_t  valid/ready
//  event_ch   out  event_t   valid/ready
//  cfg        in   enable    cfg_we/cfg_wdata
//
// A report is accepted in ST_IDLE and compared in ST_CALC. ST_EMIT then
// moves one event per cycle into the single registered output while it is
// free, and commits with the last one. A rejected report is dropped.
// The edge that loads the last event into the output register also reopens
// the input, so the next report can be taken while that event still waits.
// Reset clears enable, the previous report and all control state.
`include "hid_keyboard_report_diff_unit_macros.svh"

module hid_keyboard_report_diff_unit
	import hkrd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	hkrd_stream_if.sink   report_ch,
	hkrd_stream_if.source event_ch
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      report_ready;

	assign report_ch.ready = report_ready;

	hkrd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_ch.valid),
		.report_ready (report_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	hkrd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.report    (report_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.event_ch  (event_ch)
	);

	// No new report is taken while events are still pending.
	`HKRD_ASSERT_SAME(a_busy_blocks_input, clk, arst_n, !sts.mask_empty, !report_ready)
	// Loading a report closes the input until its events are done.
	`HKRD_ASSERT_NEXT(a_load_closes_input, clk, arst_n, cmd.load, !report_ready)
	// Emitting the final event reopens the input.
	`HKRD_ASSERT_NEXT(a_last_reopens, clk, arst_n, cmd.emit && sts.last_pick, report_ready)

endmodule
